/* sv/keyed_counter_table_top_defines.svh */
// ----------------------------------------------------------------------------
// keyed_counter_table_top_defines.svh
// Assertion macros for the keyed counter table.
// ----------------------------------------------------------------------------
`ifndef KEYED_COUNTER_TABLE_TOP_DEFINES_SVH
`define KEYED_COUNTER_TABLE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on aclk, off while in reset
`define KCT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("keyed_counter_table: assertion failed");

// next-cycle implication, sampled on aclk, off while in reset
`define KCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("keyed_counter_table: assertion failed");

`else

`define KCT_ASSERT_NOW(label, ante, cons)
`define KCT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* sv/kct_pkg.sv */
// ----------------------------------------------------------------------------
// kct_pkg
// Types, constants and helpers shared by the keyed counter table.
// ----------------------------------------------------------------------------
`default_nettype none

package kct_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int KEY_BITS    = 16;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int TAG_W       = 16;
    localparam int COUNT_W     = 32;

    // command codes
    localparam logic [1:0] CMD_ADD      = 2'd0;
    localparam logic [1:0] CMD_OVERRIDE = 2'd1;
    localparam logic [1:0] CMD_REMOVE   = 2'd2;
    localparam logic [1:0] CMD_QUERY    = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]                command;
        logic [TAG_W-1:0]          tag_key;
        logic signed [COUNT_W-1:0] amount;
    } in_beat_t;

    typedef struct packed {
        logic                      found;
        logic signed [COUNT_W-1:0] entry_count;
        logic [1:0]                status;
    } out_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_RESP
    } state_t;

    // controller to memories
    typedef struct packed {
        logic                rd_en;
        logic [ADDR_W-1:0]   rd_addr;
        logic [ADDR_W-1:0]   wr_addr;
        logic                key_wr_en;
        logic                cnt_wr_en;
        logic [KEY_BITS-1:0] wr_key;
        logic [COUNT_W-1:0]  wr_count;
    } mem_req_t;

    // controller status for the top level
    typedef struct packed {
        logic [CNT_W-1:0] used;
        logic             busy;
    } ctrl_stat_t;

    // tag field to stored key width (zero fill or truncate)
    function automatic logic [KEY_BITS-1:0] to_key(input logic [TAG_W-1:0] tag);
        logic [63:0]         wide;
        logic [KEY_BITS-1:0] k;
        wide = {{(64 - TAG_W){1'b0}}, tag};
        for (int i = 0; i < KEY_BITS; i++) begin
            k[i] = wide[i];
        end
        return k;
    endfunction

endpackage

`default_nettype wire

/* sv/kct_ram.sv */
// ----------------------------------------------------------------------------
// kct_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kct_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* sv/kct_ctrl.sv */
// ----------------------------------------------------------------------------
// kct_ctrl
// Sequencer: scans the occupied entries, then reads, modifies and writes back.
// ----------------------------------------------------------------------------
`default_nettype none

module kct_ctrl import kct_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire in_beat_t            in_beat,
    output mem_req_t                 mem_req,
    input  wire logic [KEY_BITS-1:0] rd_key,
    input  wire logic [COUNT_W-1:0]  rd_count,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output out_beat_t                res_beat,
    output ctrl_stat_t               stat
);

    state_t              state_reg, state_next;
    logic [1:0]          cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [COUNT_W-1:0]  amt_reg, amt_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0]   pend_idx_reg, pend_idx_next;
    logic                hit_reg, hit_next;
    logic [ADDR_W-1:0]   slot_reg, slot_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    out_beat_t           res_reg, res_next;

    logic                match;
    logic                more;

    // update decision
    logic                upd_found;
    logic [COUNT_W-1:0]  upd_count;
    logic [1:0]          upd_status;
    logic                upd_cnt_wr;
    logic                upd_key_wr;
    logic [COUNT_W-1:0]  upd_new;
    logic                upd_append;
    logic                amt_positive;

    // scan compare on the beat read last cycle
    assign match = pend_valid_reg && (rd_key == key_reg);
    assign more  = rd_idx_reg < used_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (match || !more) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // read-modify-write decision for the current command
    always_comb begin
        amt_positive = (amt_reg != '0) && !amt_reg[COUNT_W-1];
        upd_found    = hit_reg;
        upd_count    = hit_reg ? cnt_reg : '0;
        upd_status   = STATUS_OK;
        upd_cnt_wr   = 1'b0;
        upd_key_wr   = 1'b0;
        upd_append   = 1'b0;
        upd_new      = cnt_reg;
        if (cmd_reg == CMD_QUERY) begin
            upd_status = STATUS_OK;
        end else if (key_reg == '0) begin
            upd_found  = 1'b0;
            upd_count  = '0;
            upd_status = STATUS_INVALID;
        end else if (cmd_reg == CMD_REMOVE) begin
            if (!amt_positive) begin
                upd_status = STATUS_INVALID;
            end else if (hit_reg) begin
                upd_new    = cnt_reg - amt_reg;
                upd_cnt_wr = 1'b1;
                upd_count  = upd_new;
            end
        end else if (hit_reg) begin
            upd_new    = (cmd_reg == CMD_ADD) ? (cnt_reg + amt_reg) : amt_reg;
            upd_cnt_wr = 1'b1;
            upd_count  = upd_new;
        end else if (used_reg < CNT_W'(TABLE_DEPTH)) begin
            upd_new    = amt_reg;
            upd_cnt_wr = 1'b1;
            upd_key_wr = 1'b1;
            upd_append = 1'b1;
            upd_count  = amt_reg;
        end else begin
            upd_count  = '0;
            upd_status = STATUS_FULL;
        end
    end

    // outputs and datapath next values
    always_comb begin
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        amt_next        = amt_reg;
        rd_idx_next     = rd_idx_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        cnt_next        = cnt_reg;
        used_next       = used_reg;
        res_next        = res_reg;

        in_ready         = (state_reg == ST_IDLE);
        res_valid        = (state_reg == ST_RESP);
        mem_req.rd_en    = 1'b0;
        mem_req.rd_addr  = rd_idx_reg[ADDR_W-1:0];
        mem_req.wr_addr  = hit_reg ? slot_reg : used_reg[ADDR_W-1:0];
        mem_req.key_wr_en = 1'b0;
        mem_req.cnt_wr_en = 1'b0;
        mem_req.wr_key   = key_reg;
        mem_req.wr_count = upd_new;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd_next    = in_beat.command;
                    key_next    = to_key(in_beat.tag_key);
                    amt_next    = in_beat.amount;
                    rd_idx_next = '0;
                    hit_next    = 1'b0;
                end
            end
            ST_SCAN: begin
                if (match) begin
                    hit_next  = 1'b1;
                    slot_next = pend_idx_reg;
                    cnt_next  = rd_count;
                end else if (more) begin
                    mem_req.rd_en   = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_idx_next   = rd_idx_reg[ADDR_W-1:0];
                    rd_idx_next     = rd_idx_reg + 1'b1;
                end
            end
            ST_UPDATE: begin
                mem_req.cnt_wr_en = upd_cnt_wr;
                mem_req.key_wr_en = upd_key_wr;
                if (upd_append) begin
                    used_next = used_reg + 1'b1;
                end
                res_next.found       = upd_found;
                res_next.entry_count = upd_count;
                res_next.status      = upd_status;
            end
            ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        amt_reg      <= amt_next;
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= pend_idx_next;
        hit_reg      <= hit_next;
        slot_reg     <= slot_next;
        cnt_reg      <= cnt_next;
        res_reg      <= res_next;
    end

    assign res_beat  = res_reg;
    assign stat.used = used_reg;
    assign stat.busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

/* sv/keyed_counter_table_top.sv */
// ----------------------------------------------------------------------------
// keyed_counter_table_top
// Table of key and signed count pairs with add, override, remove and query.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat per command (command, tag_key, amount), valid/ready.
//   m_ channel: one result beat per command (found, entry_count, status).
//   Keys and counts sit in two RAMs with registered reads. A command scans the
//   occupied entries in fill order, one key RAM read per cycle, stops at the
//   first match, then writes back in the update state and passes the result
//   to the output register from the response state.
//   A miss scans all occupied entries, at most TABLE_DEPTH. One command is
//   handled at a time; the next input beat is taken once the result has
//   entered the output register, so the scan length sets the command rate.
//   The result register holds a beat while m_ready is low and a new command
//   is already accepted meanwhile; its result waits until the register frees.
//   Reset empties the table (fill count to zero) and drops any held result;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyed_counter_table_top_defines.svh"

module keyed_counter_table_top import kct_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_beat_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_data
);

    mem_req_t            mem_req;
    logic [KEY_BITS-1:0] rd_key;
    logic [COUNT_W-1:0]  rd_count;
    logic                res_valid;
    logic                res_ready;
    out_beat_t           res_beat;
    ctrl_stat_t          stat;

    logic                m_valid_reg, m_valid_next;
    out_beat_t           m_data_reg, m_data_next;

    // sequencer
    kct_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_beat   (s_data),
        .mem_req   (mem_req),
        .rd_key    (rd_key),
        .rd_count  (rd_count),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_beat  (res_beat),
        .stat      (stat)
    );

    // key store
    kct_ram #(
        .WIDTH  (KEY_BITS),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (mem_req.key_wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_key),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_key)
    );

    // count store
    kct_ram #(
        .WIDTH  (COUNT_W),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (mem_req.cnt_wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_count),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_count)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `KCT_ASSERT_NOW(a_used_bound, 1'b1, stat.used <= CNT_W'(TABLE_DEPTH))
    `KCT_ASSERT_NEXT(a_used_step, 1'b1, (stat.used - $past(stat.used)) <= CNT_W'(1))
    `KCT_ASSERT_NOW(a_full_empty, m_valid && (m_data.status == STATUS_FULL), !m_data.found && (m_data.entry_count == '0))
    `KCT_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready && stat.busy)

endmodule

`default_nettype wire
